[rtl/core/eerp_pkg.sv]
package eerp_pkg;

  // result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NUMBER     = 2'd0,
    ERR_TOO_LONG   = 2'd1,
    ERR_NO_NEWLINE = 2'd2
  } err_t;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  localparam logic [10:0] BYTES_SAT = 11'd2047;

  localparam int TDATA_W = 144;
  localparam int TUSER_W = 2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [31:0] flags;
    logic [8:0]  rune_count;
    logic [10:0] byte_count;
    err_t        error_code;
  } result_t;

endpackage

[rtl/core/eerp_in_stage.sv]
module eerp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_data,
  input  logic       take,
  output logic       valid,
  output logic [7:0] data
);

  // refill in the same cycle the held byte is consumed
  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data <= s_data;
    end
  end

endmodule

[rtl/core/eerp_dec_acc.sv]
module eerp_dec_acc (
  input  logic [31:0] acc,
  input  logic [3:0]  digit,
  output logic [31:0] sum
);

  logic [35:0] wide;

  // acc * 10 + digit as two shifts and adds
  assign wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, digit};

  // saturate at all ones
  assign sum = (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];

endmodule

[rtl/core/eerp_parser.sv]
module eerp_parser #(
  parameter int MAX_RUNES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              out_space,
  output logic              take,
  output logic              res_valid,
  output eerp_pkg::result_t res
);

  import eerp_pkg::*;

  localparam int CW = $clog2(MAX_RUNES + 1);

  typedef enum logic [7:0] {
    ST_C1   = 8'b0000_0001,
    ST_C2   = 8'b0000_0010,
    ST_NUM0 = 8'b0000_0100,
    ST_NUM1 = 8'b0000_1000,
    ST_NUM2 = 8'b0001_0000,
    ST_NUM3 = 8'b0010_0000,
    ST_TEXT = 8'b0100_0000,
    ST_NL   = 8'b1000_0000
  } state_t;

  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    if (b < 8'h80)      return 2'd0;
    else if (b < 8'hE0) return 2'd1;
    else if (b < 8'hF0) return 2'd2;
    else                return 2'd3;
  endfunction

  state_t      state, state_next;
  logic [31:0] acc, acc_next;
  logic [15:0] kind_chars, kind_chars_next;
  logic [31:0] num0, num0_next;
  logic [31:0] num1, num1_next;
  logic [31:0] num2, num2_next;
  logic [CW-1:0] saved_runes, saved_runes_next;
  logic [CW-1:0] runes_left, runes_left_next;
  logic [1:0]  rune_bytes, rune_bytes_next;
  logic [10:0] text_bytes, text_bytes_next;

  logic [31:0]   acc_mac;
  logic          is_digit;

  eerp_dec_acc u_dec_acc (
    .acc   (acc),
    .digit (in_byte[3:0]),
    .sum   (acc_mac)
  );

  assign take     = in_valid && out_space;
  assign is_digit = (in_byte >= CHAR_0) && (in_byte <= CHAR_9);

  always_comb begin
    state_next       = state;
    acc_next         = acc;
    kind_chars_next  = kind_chars;
    num0_next        = num0;
    num1_next        = num1;
    num2_next        = num2;
    saved_runes_next = saved_runes;
    runes_left_next  = runes_left;
    rune_bytes_next  = rune_bytes;
    text_bytes_next  = text_bytes;
    res_valid        = 1'b0;
    res              = '0;

    unique case (state) inside
      ST_C1: begin
        kind_chars_next = {in_byte, 8'd0};
        state_next      = ST_C2;
      end
      ST_C2: begin
        kind_chars_next = {kind_chars[15:8], in_byte};
        acc_next        = '0;
        state_next      = ST_NUM0;
      end
      ST_NUM0, ST_NUM1, ST_NUM2, ST_NUM3: begin
        if (is_digit) begin
          acc_next = acc_mac;
        end else if (in_byte != CHAR_SPACE) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NUMBER;
          state_next     = ST_C1;
        end else if (state == ST_NUM3) begin
          if (acc > 32'(MAX_RUNES)) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
            state_next     = ST_C1;
          end else begin
            saved_runes_next = acc[CW-1:0];
            runes_left_next  = acc[CW-1:0];
            rune_bytes_next  = 2'd0;
            text_bytes_next  = '0;
            state_next       = (acc == 32'd0) ? ST_NL : ST_TEXT;
          end
        end else begin
          // field separator: bank the number and move on
          acc_next = '0;
          if (state == ST_NUM0) begin
            num0_next  = acc;
            state_next = ST_NUM1;
          end else if (state == ST_NUM1) begin
            num1_next  = acc;
            state_next = ST_NUM2;
          end else begin
            num2_next  = acc;
            state_next = ST_NUM3;
          end
        end
      end
      ST_TEXT: begin
        res_valid     = 1'b1;
        res.kind      = KIND_TEXT;
        res.text_byte = in_byte;
        if (text_bytes < BYTES_SAT) begin
          text_bytes_next = text_bytes + 11'd1;
        end
        if (rune_bytes != 2'd0) begin
          rune_bytes_next = rune_bytes - 2'd1;
        end else begin
          rune_bytes_next = lead_extra(in_byte);
        end
        // rune done once its trailing bytes are used up
        if (rune_bytes_next == 2'd0) begin
          if (runes_left != '0) begin
            runes_left_next = runes_left - CW'(1);
          end
          if (runes_left_next == '0) begin
            state_next = ST_NL;
          end
        end
      end
      ST_NL: begin
        res_valid  = 1'b1;
        state_next = ST_C1;
        if (in_byte != CHAR_NL) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NO_NEWLINE;
        end else begin
          res.kind        = KIND_EVENT;
          res.first_char  = kind_chars[15:8];
          res.second_char = kind_chars[7:0];
          res.start_pos   = num0;
          res.end_pos     = num1;
          res.flags       = num2;
          res.rune_count  = 9'(saved_runes);
          res.byte_count  = text_bytes;
        end
      end
      default: begin
        state_next = ST_C1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_C1;
      acc         <= '0;
      kind_chars  <= '0;
      num0        <= '0;
      num1        <= '0;
      num2        <= '0;
      saved_runes <= '0;
      runes_left  <= '0;
      rune_bytes  <= '0;
      text_bytes  <= '0;
    end else if (take) begin
      state       <= state_next;
      acc         <= acc_next;
      kind_chars  <= kind_chars_next;
      num0        <= num0_next;
      num1        <= num1_next;
      num2        <= num2_next;
      saved_runes <= saved_runes_next;
      runes_left  <= runes_left_next;
      rune_bytes  <= rune_bytes_next;
      text_bytes  <= text_bytes_next;
    end
  end

endmodule

[rtl/core/eerp_out_stage.sv]
module eerp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              res_valid,
  input  eerp_pkg::result_t res,
  output logic              space,
  output logic              m_valid,
  input  logic              m_ready,
  output eerp_pkg::result_t m_res
);

  import eerp_pkg::*;

  // free when empty or being drained this cycle
  assign space = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (space) begin
      m_valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && take && res_valid) begin
      m_res <= res;
    end
  end

endmodule

[rtl/core/editor_event_record_parser.sv]
// Path: an accepted byte goes through the input register, then the result register, to its result word.
// Throughput: one byte per cycle, sustained, as long as the result side keeps up.
// Each cycle's path: one state decode plus a saturating acc*10+digit (shift-add, 36 bits).
// Reset: rst is synchronous, active high; clears both stage valids and puts the parser
// in the wait-for-origin-char state with all counters and saved fields at zero.
module editor_event_record_parser #(
  parameter int MAX_RUNES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream: one raw byte per word
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0 up: text_byte[7:0], first_char[15:8], second_char[23:16],
  // start_pos[55:24], end_pos[87:56], flags[119:88], rune_count[128:120],
  // byte_count[139:129], error_code[141:140], zero pad[143:142]
  output logic [eerp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [eerp_pkg::TUSER_W-1:0]  m_axis_tuser    // [1:0] kind
);

  import eerp_pkg::*;

  // Stage 1: byte register. Stage 2: parser state update feeding the result register.
  // The result register frees itself in the cycle its word is taken, so both stages
  // advance together whenever the downstream side is ready.

  logic       in_valid;
  logic [7:0] in_byte;
  logic       take;
  logic       out_space;
  logic       res_valid;
  result_t    res;
  result_t    m_res;

  eerp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .take    (take),
    .valid   (in_valid),
    .data    (in_byte)
  );

  // record parser: origin/type chars, four space-ended numbers, runes, newline
  eerp_parser #(
    .MAX_RUNES (MAX_RUNES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .out_space (out_space),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  eerp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .space     (out_space),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (m_res)
  );

  // pack the result word; fields unused by a kind are already zero
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tdata = {2'b00,
                         m_res.error_code,
                         m_res.byte_count,
                         m_res.rune_count,
                         m_res.flags,
                         m_res.end_pos,
                         m_res.start_pos,
                         m_res.second_char,
                         m_res.first_char,
                         m_res.text_byte};

endmodule
